// File: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define GFP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gfp assertion failed");

// checked on every edge, reset included
`define GFP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gfp assertion failed");

`endif

// File: hw/rtl/gfp_pkg.sv
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared constants and types for the genotype field parser.
// ----------------------------------------------------------------------------
package gfp_pkg;

  localparam int unsigned MAX_INDIVIDUALS_DEF = 65536;
  localparam int unsigned MAX_SUBFIELDS_DEF   = 16;
  localparam int unsigned QUEUE_DEPTH_DEF     = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  localparam logic [2:0] GT_LEN_CALLED = 3'd3;
  localparam logic [2:0] GT_LEN_SAT    = 3'd4;

  localparam logic [1:0] GT_CALLED    = 2'd0;
  localparam logic [1:0] GT_MISSING   = 2'd1;
  localparam logic [1:0] GT_MALFORMED = 2'd2;

  localparam logic [16:0] ALT_MAX  = 17'h1FFFF;
  localparam logic [15:0] MISS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0] status;
    logic       first_alt;
    logic       second_alt;
    logic       last;
  } gfp_tok_t;

endpackage

// File: hw/rtl/gfp_queue.sv
// ----------------------------------------------------------------------------
// gfp_queue
// Small first-in first-out queue of closed token records.
// ----------------------------------------------------------------------------
module gfp_queue
  import gfp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  gfp_tok_t push_data,
  output logic     full,
  input  logic     pop,
  output gfp_tok_t pop_data,
  output logic     not_empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  gfp_tok_t      mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/gfp_front.sv
// ----------------------------------------------------------------------------
// gfp_front
// Takes text bytes, tracks the current token and closes it into a record.
// ----------------------------------------------------------------------------
module gfp_front
  import gfp_pkg::*;
#(
  parameter int unsigned MAX_SUBFIELDS = MAX_SUBFIELDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] gt_idx,
  input  logic       in_valid,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       in_ready,
  input  logic       q_full,
  output logic       q_push,
  output gfp_tok_t   q_data
);

  localparam int unsigned SW = $clog2(MAX_SUBFIELDS + 1);
  localparam int unsigned XW = (SW > 4) ? SW : 4;
  localparam logic [SW-1:0] SUB_MAX = SW'(MAX_SUBFIELDS);

  logic [SW-1:0] subf_r, subf_nxt, subf_t;
  logic [2:0]    len_r, len_nxt, len_t;
  logic [7:0]    first_r, first_nxt, first_t;
  logic [7:0]    third_r, third_nxt, third_t;
  logic          accept, is_sep, is_colon, take, close;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_sep   = (in_char == CH_SPACE) || (in_char == CH_TAB);
  assign is_colon = (in_char == CH_COLON);
  assign take     = !is_sep && !is_colon && (XW'(subf_r) == XW'(gt_idx));
  assign close    = is_sep || in_last;

  always_comb begin
    subf_t  = subf_r;
    len_t   = len_r;
    first_t = first_r;
    third_t = third_r;
    if (is_colon && subf_r < SUB_MAX) begin
      subf_t = subf_r + 1'b1;
    end
    if (take) begin
      if (len_r == 3'd0) begin
        first_t = in_char;
      end
      if (len_r == 3'd2) begin
        third_t = in_char;
      end
      if (len_r < GT_LEN_SAT) begin
        len_t = len_r + 1'b1;
      end
    end
  end

  always_comb begin
    q_data = '0;
    if (len_t == GT_LEN_CALLED) begin
      if (first_t == CH_DOT || third_t == CH_DOT) begin
        q_data.status = GT_MISSING;
      end else begin
        q_data.status     = GT_CALLED;
        q_data.first_alt  = (first_t != CH_ZERO);
        q_data.second_alt = (third_t != CH_ZERO);
      end
    end else begin
      q_data.status = GT_MALFORMED;
    end
    q_data.last = in_last;
  end

  assign q_push = accept && close;

  always_comb begin
    subf_nxt  = subf_r;
    len_nxt   = len_r;
    first_nxt = first_r;
    third_nxt = third_r;
    if (accept) begin
      if (close) begin
        subf_nxt  = '0;
        len_nxt   = '0;
        first_nxt = '0;
        third_nxt = '0;
      end else begin
        subf_nxt  = subf_t;
        len_nxt   = len_t;
        first_nxt = first_t;
        third_nxt = third_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subf_r  <= '0;
      len_r   <= '0;
      first_r <= '0;
      third_r <= '0;
    end else begin
      subf_r  <= subf_nxt;
      len_r   <= len_nxt;
      first_r <= first_nxt;
      third_r <= third_nxt;
    end
  end

endmodule

// File: hw/rtl/gfp_back.sv
// ----------------------------------------------------------------------------
// gfp_back
// Numbers closed tokens, keeps record totals and drives the result register.
// ----------------------------------------------------------------------------
module gfp_back
  import gfp_pkg::*;
#(
  parameter int unsigned MAX_INDIVIDUALS = MAX_INDIVIDUALS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  gfp_tok_t    q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_index,
  output logic [1:0]  out_status,
  output logic        out_first_alt,
  output logic        out_second_alt,
  output logic [16:0] out_alt_total,
  output logic [15:0] out_miss_total,
  output logic        out_last
);

  localparam int unsigned LIM = (MAX_INDIVIDUALS - 1 < 65535) ? MAX_INDIVIDUALS - 1 : 65535;
  localparam logic [15:0] IND_LIMIT = 16'(LIM);

  logic [15:0] ind_r, ind_nxt;
  logic [16:0] alt_r, alt_nxt, alt_upd;
  logic [15:0] miss_r, miss_nxt, miss_upd;
  logic [17:0] alt_sum;
  logic        valid_r, valid_nxt, called;

  logic [15:0] idx_o_r;
  logic [1:0]  status_o_r;
  logic        fa_o_r, sa_o_r, last_o_r;
  logic [16:0] alt_o_r;
  logic [15:0] miss_o_r;

  assign q_pop   = q_valid && (!valid_r || out_ready);
  assign called  = (q_data.status == GT_CALLED);
  assign alt_sum = {1'b0, alt_r} + 18'(q_data.first_alt) + 18'(q_data.second_alt);

  always_comb begin
    alt_upd  = alt_r;
    miss_upd = miss_r;
    if (called) begin
      alt_upd = (alt_sum > 18'(ALT_MAX)) ? ALT_MAX : alt_sum[16:0];
    end else if (miss_r != MISS_MAX) begin
      miss_upd = miss_r + 1'b1;
    end
  end

  always_comb begin
    ind_nxt   = ind_r;
    alt_nxt   = alt_r;
    miss_nxt  = miss_r;
    valid_nxt = valid_r && !out_ready;
    if (q_pop) begin
      valid_nxt = 1'b1;
      if (q_data.last) begin
        ind_nxt  = '0;
        alt_nxt  = '0;
        miss_nxt = '0;
      end else begin
        alt_nxt  = alt_upd;
        miss_nxt = miss_upd;
        if (ind_r < IND_LIMIT) begin
          ind_nxt = ind_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      idx_o_r    <= ind_r;
      status_o_r <= q_data.status;
      fa_o_r     <= q_data.first_alt;
      sa_o_r     <= q_data.second_alt;
      alt_o_r    <= alt_upd;
      miss_o_r   <= miss_upd;
      last_o_r   <= q_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ind_r   <= '0;
      alt_r   <= '0;
      miss_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      ind_r   <= ind_nxt;
      alt_r   <= alt_nxt;
      miss_r  <= miss_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_index      = idx_o_r;
  assign out_status     = status_o_r;
  assign out_first_alt  = fa_o_r;
  assign out_second_alt = sa_o_r;
  assign out_alt_total  = alt_o_r;
  assign out_miss_total = miss_o_r;
  assign out_last       = last_o_r;

endmodule

// File: hw/rtl/genotype_field_parser.sv
// ----------------------------------------------------------------------------
// genotype_field_parser
// Parses sample-column text bytes and reports one genotype status per
// individual, with running alternate-allele and missing totals per record.
//
//   channel | dir | tdata                         | tlast
//   in_     | in  | text_char                     | end_of_record
//   out_    | out | index, status, alts, totals   | last_of_record
//   cfg_    | in  | gt_subfield_index (wdata)     | -
//
// one byte per cycle while the token queue is not full; a closing byte's result
// is offered at the earliest after passing through the token queue and then the
// output register of the back end
// the token queue between front and back absorbs output stalls; input
// stalls only once the queue is full
// synchronous active-low reset clears token state, totals and the queue
// ----------------------------------------------------------------------------
module genotype_field_parser
  import gfp_pkg::*;
#(
  parameter int unsigned MAX_INDIVIDUALS = MAX_INDIVIDUALS_DEF,
  parameter int unsigned MAX_SUBFIELDS   = MAX_SUBFIELDS_DEF,
  parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_char
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // individual_index, genotype_status, first_allele_alt,
                                  // second_allele_alt, alt_allele_total, missing_total
  output logic        out_tlast
);

  logic [3:0]  gt_idx_r;
  logic        q_full, q_push, q_pop, q_valid;
  gfp_tok_t    q_wdata, q_rdata;
  logic [15:0] o_index;
  logic [1:0]  o_status;
  logic        o_fa, o_sa;
  logic [16:0] o_alt;
  logic [15:0] o_miss;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gt_idx_r <= '0;
    end else if (cfg_wen) begin
      gt_idx_r <= cfg_wdata;
    end
  end

  gfp_front #(
    .MAX_SUBFIELDS(MAX_SUBFIELDS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .gt_idx   (gt_idx_r),
    .in_valid (in_tvalid),
    .in_char  (in_tdata),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  gfp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .not_empty (q_valid)
  );

  gfp_back #(
    .MAX_INDIVIDUALS(MAX_INDIVIDUALS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_index      (o_index),
    .out_status     (o_status),
    .out_first_alt  (o_fa),
    .out_second_alt (o_sa),
    .out_alt_total  (o_alt),
    .out_miss_total (o_miss),
    .out_last       (out_tlast)
  );

  assign out_tdata = {3'b000, o_miss, o_alt, o_sa, o_fa, o_status, o_index};

endmodule

// File: hw/rtl/gfp_checker.sv
// ----------------------------------------------------------------------------
// gfp_checker
// Port-level checks on the genotype field parser result channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfp_checker
  import gfp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast
);

  logic [1:0]  res_status;
  logic [1:0]  res_alts;
  logic [15:0] res_miss;
  logic        stalled, not_called, status_ok;

  assign res_status = out_tdata[17:16];
  assign res_alts   = out_tdata[19:18];
  assign res_miss   = out_tdata[52:37];
  assign stalled    = out_tvalid && !out_tready;
  assign not_called = out_tvalid && (res_status != GT_CALLED);
  assign status_ok  = (res_status == GT_CALLED) || (res_status == GT_MISSING) ||
                      (res_status == GT_MALFORMED);

  `GFP_ASSERT(a_hold_stall, clk, rst_n, stalled |=> out_tvalid && $stable({out_tlast, out_tdata}))
  `GFP_ASSERT(a_flags_called, clk, rst_n, not_called |-> res_alts == 2'b00)
  `GFP_ASSERT(a_miss_counted, clk, rst_n, not_called |-> res_miss != 16'd0)
  `GFP_ASSERT(a_status_code, clk, rst_n, out_tvalid |-> status_ok)
  `GFP_ASSERT_ALWAYS(a_reset_idle, clk, $past(!rst_n) |-> !out_tvalid)

endmodule

bind genotype_field_parser gfp_checker u_gfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
